/* sv/dilpt_pkg.sv */
`timescale 1ns / 1ps
// Package for the dual-index linear-probe table: sizes, codes, entry and result types.
// No dependencies; every other file of the block imports it.

package dilpt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int HASH_W      = 31;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = 8;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [HASH_W-1:0] t_hash;

    localparam t_idx IDX_LAST = t_idx'(TABLE_DEPTH - 1);

    localparam logic [KIND_W-1:0] KIND_INSERT     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FWD_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REV_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FWD_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_REV_FULL  = 2'd3;

    typedef struct packed {
        logic  valid;
        t_hash cate;
        t_hash item;
        t_hash value;
    } t_fwd_entry;

    typedef struct packed {
        logic  valid;
        t_hash cate;
        t_hash item;
        t_idx  slot;
        t_hash value;
    } t_rev_entry;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        t_hash               value;
        t_hash               cate;
        t_hash               item;
    } t_result;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_FWD_RD,
        ST_FWD_CHK,
        ST_REV_RD,
        ST_REV_CHK,
        ST_LINK_RD,
        ST_LINK_CHK,
        ST_DONE
    } t_state;

    function automatic logic [SLOT_W-1:0] slot_of(input t_idx idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

/* sv/dilpt_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response words.
// Depends on dilpt_pkg.

interface dilpt_req_if;
    import dilpt_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    t_hash             cmd_hash;
    t_hash             cate_key;
    t_hash             item_key;
    t_hash             value_hash;

    modport source (output valid, kind, cmd_hash, cate_key, item_key, value_hash,
                    input ready);
    modport sink   (input valid, kind, cmd_hash, cate_key, item_key, value_hash,
                    output ready);
endinterface

interface dilpt_rsp_if;
    import dilpt_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    t_hash               found_value;
    t_hash               found_cate;
    t_hash               found_item;

    modport source (output valid, status, slot, found_value, found_cate, found_item,
                    input ready);
    modport sink   (input valid, status, slot, found_value, found_cate, found_item,
                    output ready);
endinterface

/* sv/dilpt_mod.sv */
`timescale 1ns / 1ps
// Registered reduction of a 31-bit hash modulo TABLE_DEPTH; result ready the cycle after start.
// Depends on dilpt_pkg.

module dilpt_mod (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  dilpt_pkg::t_hash i_value,
    output logic             o_done,
    output dilpt_pkg::t_idx  o_rem
);
    import dilpt_pkg::*;

    logic r_done;
    t_idx r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= t_idx'(i_value % HASH_W'(TABLE_DEPTH));
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* sv/dual_index_linear_probe_table.sv */
`timescale 1ns / 1ps
// Top level of the dual-index linear-probe table: sequencer, both table memories, result register.
// Depends on dilpt_pkg, dilpt_if (dilpt_req_if, dilpt_rsp_if) and dilpt_mod.
//
// After reset the block sweeps both tables empty, one slot per cycle, with i_req.ready low.
// It then takes one request word at a time and answers each with exactly one response word.
// Every request of a known kind first reduces its hash modulo TABLE_DEPTH in a registered
// unit, then probes one slot at a time through the registered read port of a table memory,
// with a read state and then a check state per slot. A reverse lookup also reads the forward
// slot that each occupied entry links to; an insert takes two reductions plus both probe runs.
// A finished response waits in the output register while the next request is already accepted.

module dual_index_linear_probe_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dilpt_req_if.sink    i_req,
    dilpt_rsp_if.source  o_rsp
);
    import dilpt_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [KIND_W-1:0] r_kind;
    t_hash             r_cate;
    t_hash             r_item;
    t_hash             r_val;
    logic              r_rev_phase;
    t_idx              r_idx;
    t_idx              r_cnt;
    t_idx              r_fslot;
    t_fwd_entry        r_fdata;
    t_rev_entry        r_rdata;
    t_result           r_res;
    t_result           n_res;
    logic              r_out_valid;
    t_result           r_out;

    t_fwd_entry        r_fwd_mem [TABLE_DEPTH];
    t_rev_entry        r_rev_mem [TABLE_DEPTH];

    logic              req_acc;
    logic              kind_known;
    logic              last;
    logic              fwd_we;
    logic              rev_we;
    logic              fwd_rd;
    logic              rev_rd;
    t_idx              fwd_raddr;
    t_fwd_entry        fwd_wdata;
    t_rev_entry        rev_wdata;
    logic              mod_start;
    t_hash             mod_value;
    logic              mod_done;
    t_idx              mod_rem;
    logic              adv;
    logic              res_load;
    logic              out_load;
    logic              fwd_hit;
    logic              link_hit;

    assign i_req.ready = (r_state == ST_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign kind_known  = i_req.kind inside {KIND_INSERT, KIND_FWD_LOOKUP, KIND_REV_LOOKUP};
    assign last        = (r_cnt == IDX_LAST);
    assign out_load    = (r_state == ST_DONE) && (!r_out_valid || o_rsp.ready);

    assign fwd_hit  = r_fdata.valid && (r_fdata.cate == r_cate) && (r_fdata.item == r_item);
    assign link_hit = r_fdata.valid && (r_rdata.cate == r_fdata.cate) &&
                      (r_rdata.item == r_fdata.item) && (r_rdata.value == r_val);

    dilpt_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (mod_value),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (fwd_we) begin
            r_fwd_mem[r_idx] <= fwd_wdata;
        end
        if (fwd_rd) begin
            r_fdata <= r_fwd_mem[fwd_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rev_we) begin
            r_rev_mem[r_idx] <= rev_wdata;
        end
        if (rev_rd) begin
            r_rdata <= r_rev_mem[r_idx];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_idx == IDX_LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (req_acc) n_state = kind_known ? ST_HASH : ST_DONE;
            end
            ST_HASH: begin
                if (mod_done) begin
                    if ((r_kind == KIND_REV_LOOKUP) || r_rev_phase) n_state = ST_REV_RD;
                    else                                            n_state = ST_FWD_RD;
                end
            end
            ST_FWD_RD:  n_state = ST_FWD_CHK;
            ST_FWD_CHK: begin
                if (mod_start)     n_state = ST_HASH;
                else if (res_load) n_state = ST_DONE;
                else               n_state = ST_FWD_RD;
            end
            ST_REV_RD:  n_state = ST_REV_CHK;
            ST_REV_CHK: begin
                if (res_load)                                          n_state = ST_DONE;
                else if ((r_kind == KIND_REV_LOOKUP) && r_rdata.valid) n_state = ST_LINK_RD;
                else                                                   n_state = ST_REV_RD;
            end
            ST_LINK_RD:  n_state = ST_LINK_CHK;
            ST_LINK_CHK: n_state = res_load ? ST_DONE : ST_REV_RD;
            ST_DONE: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        fwd_we    = 1'b0;
        rev_we    = 1'b0;
        fwd_rd    = 1'b0;
        rev_rd    = 1'b0;
        fwd_raddr = r_idx;
        fwd_wdata = '0;
        rev_wdata = '0;
        mod_start = 1'b0;
        mod_value = r_val;
        adv       = 1'b0;
        res_load  = 1'b0;
        n_res     = '0;
        case (r_state)
            ST_CLEAR: begin
                fwd_we = 1'b1;
                rev_we = 1'b1;
            end
            ST_IDLE: begin
                mod_value = (i_req.kind == KIND_REV_LOOKUP) ? i_req.value_hash : i_req.cmd_hash;
                if (req_acc) begin
                    if (kind_known) begin
                        mod_start = 1'b1;
                    end else begin
                        res_load     = 1'b1;
                        n_res.status = STATUS_NOT_FOUND;
                    end
                end
            end
            ST_FWD_RD: fwd_rd = 1'b1;
            ST_FWD_CHK: begin
                if (r_kind == KIND_INSERT) begin
                    if (!r_fdata.valid) begin
                        fwd_we    = 1'b1;
                        fwd_wdata = '{valid: 1'b1, cate: r_cate, item: r_item, value: r_val};
                        mod_start = 1'b1;
                    end else if (last) begin
                        res_load     = 1'b1;
                        n_res.status = STATUS_FWD_FULL;
                    end else begin
                        adv = 1'b1;
                    end
                end else begin
                    if (fwd_hit) begin
                        res_load = 1'b1;
                        n_res    = '{status: STATUS_OK, slot: slot_of(r_idx),
                                     value: r_fdata.value, cate: r_fdata.cate,
                                     item: r_fdata.item};
                    end else if (last) begin
                        res_load     = 1'b1;
                        n_res.status = STATUS_NOT_FOUND;
                    end else begin
                        adv = 1'b1;
                    end
                end
            end
            ST_REV_RD: rev_rd = 1'b1;
            ST_REV_CHK: begin
                if (r_kind == KIND_INSERT) begin
                    n_res = '{status: STATUS_REV_FULL, slot: slot_of(r_fslot),
                              value: r_val, cate: r_cate, item: r_item};
                    if (!r_rdata.valid) begin
                        rev_we       = 1'b1;
                        rev_wdata    = '{valid: 1'b1, cate: r_cate, item: r_item,
                                         slot: r_fslot, value: r_val};
                        res_load     = 1'b1;
                        n_res.status = STATUS_OK;
                    end else if (last) begin
                        res_load = 1'b1;
                    end else begin
                        adv = 1'b1;
                    end
                end else if (!r_rdata.valid) begin
                    if (last) begin
                        res_load     = 1'b1;
                        n_res.status = STATUS_NOT_FOUND;
                    end else begin
                        adv = 1'b1;
                    end
                end
            end
            ST_LINK_RD: begin
                fwd_rd    = 1'b1;
                fwd_raddr = r_rdata.slot;
            end
            ST_LINK_CHK: begin
                if (link_hit) begin
                    res_load = 1'b1;
                    n_res    = '{status: STATUS_OK, slot: slot_of(r_rdata.slot),
                                 value: r_fdata.value, cate: r_fdata.cate,
                                 item: r_fdata.item};
                end else if (last) begin
                    res_load     = 1'b1;
                    n_res.status = STATUS_NOT_FOUND;
                end else begin
                    adv = 1'b1;
                end
            end
            ST_HASH, ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_rev_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_idx <= r_idx + IDX_W'(1);
            end else if ((r_state == ST_HASH) && mod_done) begin
                r_idx <= mod_rem;
                r_cnt <= '0;
            end else if (adv) begin
                r_idx <= (r_idx == IDX_LAST) ? '0 : r_idx + IDX_W'(1);
                r_cnt <= r_cnt + IDX_W'(1);
            end
            if (req_acc) begin
                r_rev_phase <= 1'b0;
            end else if ((r_state == ST_FWD_CHK) && fwd_we) begin
                r_rev_phase <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_kind <= i_req.kind;
            r_cate <= i_req.cate_key;
            r_item <= i_req.item_key;
            r_val  <= i_req.value_hash;
        end
        if ((r_state == ST_FWD_CHK) && fwd_we) begin
            r_fslot <= r_idx;
        end
        if (res_load) begin
            r_res <= n_res;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.slot        = r_out.slot;
    assign o_rsp.found_value = r_out.value;
    assign o_rsp.found_cate  = r_out.cate;
    assign o_rsp.found_item  = r_out.item;

endmodule

/* sv/dilpt_chk.sv */
`timescale 1ns / 1ps
// Port-level checker for the dual-index linear-probe table, with its bind to the top level.
// Depends on dilpt_pkg and dual_index_linear_probe_table.

module dilpt_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [dilpt_pkg::STATUS_W-1:0] i_rsp_status,
    input logic [dilpt_pkg::SLOT_W-1:0]   i_rsp_slot,
    input dilpt_pkg::t_hash               i_rsp_value,
    input dilpt_pkg::t_hash               i_rsp_cate,
    input dilpt_pkg::t_hash               i_rsp_item
);
    import dilpt_pkg::*;

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready)
        else $error("request ready during table clearing");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while previous word still in work");

    a_miss_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && ((i_rsp_status == STATUS_NOT_FOUND) ||
                         (i_rsp_status == STATUS_FWD_FULL)))
        |-> ((i_rsp_slot == '0) && (i_rsp_value == '0) && (i_rsp_cate == '0) &&
             (i_rsp_item == '0)))
        else $error("miss or forward-full response carries nonzero fields");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
        (i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_slot) &&
         $stable(i_rsp_value) && $stable(i_rsp_cate) && $stable(i_rsp_item)))
        else $error("stalled response word changed");

endmodule

bind dual_index_linear_probe_table dilpt_chk u_dilpt_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_slot   (o_rsp.slot),
    .i_rsp_value  (o_rsp.found_value),
    .i_rsp_cate   (o_rsp.found_cate),
    .i_rsp_item   (o_rsp.found_item)
);
